// ===== design/ctc_pkg.sv =====
// Shared types, constants and lookup functions of the codon translation checker.
// Holds the seventeen genetic-code tables; used by ctc_codon_unit and the core.
package ctc_pkg;

   localparam int NUM_CODES   = 17;
   localparam int NUM_TABLES  = 17;
   localparam int USED_TABLES = (NUM_CODES < NUM_TABLES) ? NUM_CODES : NUM_TABLES;
   localparam int CODE_W      = 17;
   localparam int NUM_CODONS  = 64;
   localparam int TABLE_W     = NUM_CODONS * 8;

   localparam logic [CODE_W-1:0] USED_MASK =
      CODE_W'((34'd1 << USED_TABLES) - 34'd1);

   // Letter codes
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
   localparam logic [7:0] CHAR_CASE    = 8'h20;
   localparam logic [7:0] CHAR_B       = 8'h42;
   localparam logic [7:0] CHAR_D       = 8'h44;
   localparam logic [7:0] CHAR_N       = 8'h4e;
   localparam logic [7:0] CHAR_Z       = 8'h5a;
   localparam logic [7:0] CHAR_E       = 8'h45;
   localparam logic [7:0] CHAR_Q       = 8'h51;

   // Base set bits
   localparam logic [3:0] BASE_A = 4'd1;
   localparam logic [3:0] BASE_C = 4'd2;
   localparam logic [3:0] BASE_T = 4'd8;

   // Position code for "no ambiguous position"
   localparam logic [1:0] POS_NONE = 2'd3;

   typedef enum logic [2:0] {
      CAUSE_OK        = 3'd0,
      CAUSE_THREE_AMB = 3'd1,
      CAUSE_NO_XLATE  = 3'd2,
      CAUSE_NO_TABLE  = 3'd3,
      CAUSE_COMBO     = 3'd4
   } cause_type;

   typedef struct packed {
      logic              ok;
      logic [CODE_W-1:0] left;
      cause_type         cause;
   } check_type;

   // Codon order within a table: 16*b1 + 4*b2 + b3 with T=0 C=1 A=2 G=3.
   localparam logic [TABLE_W-1:0] CODE_TABLES [NUM_TABLES] = '{
      "FFLLSSSSYY**CC*WLLLLPPPPHHQQRRRRIIIMTTTTNNKKSSRRVVVVAAAADDEEGGGG",
      "FFLLSSSSYY**CCWWLLLLPPPPHHQQRRRRIIMMTTTTNNKKSS**VVVVAAAADDEEGGGG",
      "FFLLSSSSYY**CCWWTTTTPPPPHHQQRRRRIIMMTTTTNNKKSSRRVVVVAAAADDEEGGGG",
      "FFLLSSSSYY**CCWWLLLLPPPPHHQQRRRRIIIMTTTTNNKKSSRRVVVVAAAADDEEGGGG",
      "FFLLSSSSYY**CCWWLLLLPPPPHHQQRRRRIIMMTTTTNNKKSSSSVVVVAAAADDEEGGGG",
      "FFLLSSSSYYQQCC*WLLLLPPPPHHQQRRRRIIIMTTTTNNKKSSRRVVVVAAAADDEEGGGG",
      "FFLLSSSSYY**CCWWLLLLPPPPHHQQRRRRIIIMTTTTNNNKSSSSVVVVAAAADDEEGGGG",
      "FFLLSSSSYY**CCCWLLLLPPPPHHQQRRRRIIIMTTTTNNKKSSRRVVVVAAAADDEEGGGG",
      "FFLLSSSSYY**CC*WLLLLPPPPHHQQRRRRIIIMTTTTNNKKSSRRVVVVAAAADDEEGGGG",
      "FFLLSSSSYY**CC*WLLLSPPPPHHQQRRRRIIIMTTTTNNKKSSRRVVVVAAAADDEEGGGG",
      "FFLLSSSSYY**CCWWLLLLPPPPHHQQRRRRIIMMTTTTNNKKSSGGVVVVAAAADDEEGGGG",
      "FFLLSSSSYYY*CCWWLLLLPPPPHHQQRRRRIIIMTTTTNNNKSSSSVVVVAAAADDEEGGGG",
      "FFLLSSSSYY*QCC*WLLLLPPPPHHQQRRRRIIIMTTTTNNKKSSRRVVVVAAAADDEEGGGG",
      "FFLLSSSSYY*LCC*WLLLLPPPPHHQQRRRRIIIMTTTTNNKKSSRRVVVVAAAADDEEGGGG",
      "FFLLSSSSYY**CCWWLLLLPPPPHHQQRRRRIIMMTTTTNNNKSSSSVVVVAAAADDEEGGGG",
      "FFLLSS*SYY*LCC*WLLLLPPPPHHQQRRRRIIIMTTTTNNKKSSRRVVVVAAAADDEEGGGG",
      "FF*LSSSSYY**CC*WLLLLPPPPHHQQRRRRIIIMTTTTNNKKSSRRVVVVAAAADDEEGGGG"
   };

   // First character of a string literal sits in the top byte.
   function automatic logic [7:0] table_char(input int tbl, input logic [5:0] idx);
      logic [TABLE_W-1:0] row;
      row = CODE_TABLES[tbl];
      return row[(NUM_CODONS - 1 - int'(idx)) * 8 +: 8];
   endfunction

   function automatic logic [1:0] base_order(input logic [3:0] b);
      logic [1:0] ord;
      unique case (b)
         BASE_T:  ord = 2'd0;
         BASE_C:  ord = 2'd1;
         BASE_A:  ord = 2'd2;
         default: ord = 2'd3;
      endcase
      return ord;
   endfunction

   function automatic logic is_single(input logic [3:0] b);
      return (b != 4'd0) && ((b & (b - 4'd1)) == 4'd0);
   endfunction

   function automatic logic [3:0] low_bit(input logic [3:0] b);
      return b & (~b + 4'd1);
   endfunction

endpackage

// ===== design/codon_translation_checker_core.sv =====
// Top level of the codon translation checker: sequencer, operand registers,
// result register. Depends on ctc_pkg and ctc_codon_unit.
//
// Each request carries an amino-acid letter, three IUPAC base sets and a mask
// of allowed genetic-code tables; one response tells whether the triplet
// encodes the letter, which allowed tables agree, and a failure cause. The
// sequencer walks the base combinations of the ambiguous positions in order
// (A, C, G, T at the first ambiguous position, then the second), one
// combination per cycle through a single codon check unit that compares the
// codon against all tables at once, and chains the surviving mask from one
// combination to the next. A clean triplet needs a single combination and two
// fully ambiguous positions up to 16; letters B and Z may run a second pass
// (D then N, E then Q) when the first fails. The response enters the result
// register when the last combination is checked, or is parked in a hold
// register while the result register still waits on rsp_stall; a new request
// is taken only back in idle. req_stall is high while a request is in work;
// the result register lets the next request enter while the previous
// response still waits on rsp_stall.
module codon_translation_checker_core
   import ctc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [7:0]        req_amino_letter,
   input  logic [3:0]        req_base_first,
   input  logic [3:0]        req_base_second,
   input  logic [3:0]        req_base_third,
   input  logic [CODE_W-1:0] req_codes_allowed,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_encodes,
   output logic [CODE_W-1:0] rsp_codes_left,
   output logic [2:0]        rsp_fail_cause
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_RUN  = 3'b010,
      ST_HOLD = 3'b100
   } state_type;

   state_type         state_ff, state_in;
   logic [7:0]        letter_ff, letter_in;
   logic [7:0]        alt_letter_ff, alt_letter_in;
   logic              alt_pend_ff, alt_pend_in;
   logic [3:0]        base_ff [3];
   logic [3:0]        base_in [3];
   logic [CODE_W-1:0] allowed_ff, allowed_in;
   logic [CODE_W-1:0] cur_ff, cur_in;
   logic [1:0]        pos1_ff, pos1_in;
   logic [1:0]        pos2_ff, pos2_in;
   logic [3:0]        rem1_ff, rem1_in;
   logic [3:0]        rem2_ff, rem2_in;
   cause_type         pre_cause_ff, pre_cause_in;
   logic              amb_ff, amb_in;
   check_type         res_ff, res_in;
   logic              rsp_valid_ff, rsp_valid_in;
   check_type         rsp_ff, rsp_in;

   logic              accept;
   logic              out_free;
   logic [7:0]        up_letter;
   logic [3:0]        req_base [3];
   logic              single [3];
   logic [1:0]        amb_count;
   logic              any_empty;
   logic [1:0]        first_pos, second_pos;
   logic [3:0]        low1, low2;
   logic [3:0]        cur_base [3];
   logic [5:0]        codon_idx;
   check_type         unit_res;
   logic [3:0]        rem1_next, rem2_next;
   logic              last_combo;
   logic              pass_done;
   logic              pass_fail;
   cause_type         pass_cause;
   check_type         final_res;

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = reset || (state_ff != ST_IDLE);

   // ---------------------------------------------------------------------
   // Decode a request: fold case, map B/Z to their two candidates, find the
   // ambiguous positions and the cases that fail before any table lookup.
   // ---------------------------------------------------------------------
   assign req_base[0] = req_base_first;
   assign req_base[1] = req_base_second;
   assign req_base[2] = req_base_third;

   always_comb begin
      up_letter = req_amino_letter;
      if (req_amino_letter >= CHAR_LOWER_A && req_amino_letter <= CHAR_LOWER_Z)
         up_letter = req_amino_letter - CHAR_CASE;
   end

   always_comb begin
      amb_count  = 2'd0;
      any_empty  = 1'b0;
      first_pos  = POS_NONE;
      second_pos = POS_NONE;
      for (int i = 0; i < 3; i++) begin
         single[i] = is_single(req_base[i]);
         if (!single[i]) begin
            if (req_base[i] == 4'd0) any_empty = 1'b1;
            if (first_pos == POS_NONE) first_pos = 2'(i);
            else if (second_pos == POS_NONE) second_pos = 2'(i);
            amb_count = amb_count + 2'd1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Current combination: substitute the lowest remaining base at each
   // ambiguous position and feed the codon to the shared check unit.
   // ---------------------------------------------------------------------
   assign low1 = low_bit(rem1_ff);
   assign low2 = low_bit(rem2_ff);

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         priority if (pos1_ff == 2'(i)) cur_base[i] = low1;
         else if (pos2_ff == 2'(i))     cur_base[i] = low2;
         else                           cur_base[i] = base_ff[i];
      end
   end

   assign codon_idx = {base_order(cur_base[0]), base_order(cur_base[1]),
                       base_order(cur_base[2])};

   ctc_codon_unit u_codon_unit (
      .letter    (letter_ff),
      .codon_idx (codon_idx),
      .allowed   (cur_ff),
      .result    (unit_res)
   );

   // Advance the combination counter: inner position first, then outer.
   always_comb begin
      rem1_next = rem1_ff;
      rem2_next = rem2_ff;
      if (pos2_ff != POS_NONE) begin
         rem2_next = rem2_ff & ~low2;
         if (rem2_next == 4'd0) begin
            rem1_next = rem1_ff & ~low1;
            rem2_next = base_ff[pos2_ff];
         end
      end else begin
         rem1_next = rem1_ff & ~low1;
      end
      last_combo = (pos1_ff == POS_NONE) || (rem1_next == 4'd0);
   end

   // Outcome of this cycle for the running pass.
   always_comb begin
      pass_done  = 1'b0;
      pass_fail  = 1'b0;
      pass_cause = CAUSE_OK;
      priority if (pre_cause_ff != CAUSE_OK) begin
         pass_done  = 1'b1;
         pass_fail  = 1'b1;
         pass_cause = pre_cause_ff;
      end else if (!unit_res.ok) begin
         // inside an expansion every failure is reported the same way
         pass_done  = 1'b1;
         pass_fail  = 1'b1;
         pass_cause = amb_ff ? CAUSE_COMBO : unit_res.cause;
      end else if (last_combo) begin
         pass_done  = 1'b1;
      end
   end

   always_comb begin
      final_res.ok    = !pass_fail;
      final_res.left  = pass_fail ? '0 : unit_res.left;
      final_res.cause = pass_cause;
   end

   // ---------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      letter_in     = letter_ff;
      alt_letter_in = alt_letter_ff;
      alt_pend_in   = alt_pend_ff;
      base_in       = base_ff;
      allowed_in    = allowed_ff;
      cur_in        = cur_ff;
      pos1_in       = pos1_ff;
      pos2_in       = pos2_ff;
      rem1_in       = rem1_ff;
      rem2_in       = rem2_ff;
      pre_cause_in  = pre_cause_ff;
      amb_in        = amb_ff;
      res_in        = res_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_in        = rsp_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               priority if (up_letter == CHAR_B) begin
                  letter_in     = CHAR_D;
                  alt_letter_in = CHAR_N;
                  alt_pend_in   = 1'b1;
               end else if (up_letter == CHAR_Z) begin
                  letter_in     = CHAR_E;
                  alt_letter_in = CHAR_Q;
                  alt_pend_in   = 1'b1;
               end else begin
                  letter_in     = up_letter;
                  alt_letter_in = up_letter;
                  alt_pend_in   = 1'b0;
               end
               base_in    = req_base;
               allowed_in = req_codes_allowed & USED_MASK;
               cur_in     = req_codes_allowed & USED_MASK;
               pos1_in    = first_pos;
               pos2_in    = second_pos;
               rem1_in    = (first_pos == POS_NONE) ? 4'd0 : req_base[first_pos];
               rem2_in    = (second_pos == POS_NONE) ? 4'd0 : req_base[second_pos];
               amb_in     = (amb_count != 2'd0);
               priority if (amb_count == 2'd3) pre_cause_in = CAUSE_THREE_AMB;
               else if (any_empty)             pre_cause_in = CAUSE_COMBO;
               else                            pre_cause_in = CAUSE_OK;
               state_in   = ST_RUN;
            end
         end
         ST_RUN: begin
            if (!pass_done) begin
               cur_in  = unit_res.left;
               rem1_in = rem1_next;
               rem2_in = rem2_next;
            end else if (pass_fail && alt_pend_ff) begin
               // restart with the second candidate letter
               letter_in   = alt_letter_ff;
               alt_pend_in = 1'b0;
               cur_in      = allowed_ff;
               rem1_in     = (pos1_ff == POS_NONE) ? 4'd0 : base_ff[pos1_ff];
               rem2_in     = (pos2_ff == POS_NONE) ? 4'd0 : base_ff[pos2_ff];
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = final_res;
               state_in     = ST_IDLE;
            end else begin
               res_in   = final_res;
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            // hold the response until the result register drains
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         alt_pend_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         alt_pend_ff  <= alt_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      letter_ff     <= letter_in;
      alt_letter_ff <= alt_letter_in;
      base_ff       <= base_in;
      allowed_ff    <= allowed_in;
      cur_ff        <= cur_in;
      pos1_ff       <= pos1_in;
      pos2_ff       <= pos2_in;
      rem1_ff       <= rem1_in;
      rem2_ff       <= rem2_in;
      pre_cause_ff  <= pre_cause_in;
      amb_ff        <= amb_in;
      res_ff        <= res_in;
      rsp_ff        <= rsp_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_encodes    = rsp_ff.ok;
   assign rsp_codes_left = rsp_ff.left;
   assign rsp_fail_cause = rsp_ff.cause;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   a_fail_clears_mask: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_encodes |-> rsp_codes_left == '0)
      else $error("failed response carries a nonzero mask");

   a_accept_starts_run: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff == ST_RUN)
      else $error("accepted request did not start the sequencer");

   a_hold_needs_full_output: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_HOLD |-> rsp_valid_ff)
      else $error("response parked while the result register is empty");

   a_response_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff != ST_IDLE))
      else $error("response appeared without a request in work");

endmodule

// ===== design/ctc_codon_unit.sv =====
// Shared check unit: one clean codon against all used tables, combinationally.
// Depends on ctc_pkg for the tables and the result struct.
module ctc_codon_unit
   import ctc_pkg::*;
(
   input  logic [7:0]        letter,
   input  logic [5:0]        codon_idx,
   input  logic [CODE_W-1:0] allowed,
   output check_type         result
);

   logic [CODE_W-1:0] match;
   logic              same;
   logic [7:0]        first_char;
   logic [CODE_W-1:0] kept;

   always_comb begin
      match      = '0;
      same       = 1'b1;
      first_char = table_char(0, codon_idx);
      for (int k = 0; k < USED_TABLES; k++) begin
         if (table_char(k, codon_idx) == letter) match[k] = 1'b1;
         if (table_char(k, codon_idx) != first_char) same = 1'b0;
      end
   end

   assign kept = match & allowed;

   always_comb begin
      result.ok    = 1'b0;
      result.left  = '0;
      result.cause = CAUSE_NO_XLATE;
      // tables that all agree keep the whole mask
      priority if (same) begin
         if (match != '0) begin
            result.ok    = 1'b1;
            result.left  = allowed;
            result.cause = CAUSE_OK;
         end
      end else if (match == '0) begin
         result.cause = CAUSE_NO_XLATE;
      end else if (kept == '0) begin
         result.cause = CAUSE_NO_TABLE;
      end else begin
         result.ok    = 1'b1;
         result.left  = kept;
         result.cause = CAUSE_OK;
      end
   end

endmodule
